>>> hw/rtl/vsp_pkg.sv
package vsp_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COUNT_W     = 17;
	localparam int FRAME_W     = 17;
	localparam int CH_W        = 4;
	localparam int OPCODE_W    = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int OUT_CH      = 4;
	localparam int QUEUE_DEPTH = 2;

	// Command opcodes as they arrive on the command channel
	localparam logic [OPCODE_W-1:0] OP_LOAD     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_REWIND   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SET_PLAY = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SEEK     = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_ENABLE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_FRAMES   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPEED         = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT  = 3'd4;

	typedef enum logic [2:0] {
		K_LOAD,
		K_TICK,
		K_REWIND,
		K_SET_PLAY,
		K_SEEK
	} kind_t;

	// Classified command, as queued between front and back
	typedef struct packed {
		kind_t               kind;
		logic [15:0]         addr;
		logic [SAMPLE_W-1:0] sample;
		logic                play_req;
		logic [15:0]         seek;
	} op_t;

	// Effective configuration seen by the back end
	typedef struct packed {
		logic [CH_W-1:0]     ch;
		logic [COUNT_W-1:0]  cnt;
		logic [COUNT_W-1:0]  frame_end;
		logic                loop_en;
		logic [15:0]         skip;
		logic [SAMPLE_W-1:0] speed;
	} cfg_t;

endpackage

>>> hw/rtl/vsp_cmd_if.sv
interface vsp_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [15:0]        load_address;
	logic signed [15:0] load_sample;
	logic               play_request;
	logic [15:0]        seek_frame;

	modport source (
		output valid, opcode, load_address, load_sample, play_request, seek_frame,
		input  ready
	);
	modport sink (
		input  valid, opcode, load_address, load_sample, play_request, seek_frame,
		output ready
	);
endinterface

>>> hw/rtl/vsp_result_if.sv
interface vsp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] chan0_out;
	logic signed [15:0] chan1_out;
	logic signed [15:0] chan2_out;
	logic signed [15:0] chan3_out;
	logic               is_playing;

	modport source (
		output valid, chan0_out, chan1_out, chan2_out, chan3_out, is_playing,
		input  ready
	);
	modport sink (
		input  valid, chan0_out, chan1_out, chan2_out, chan3_out, is_playing,
		output ready
	);
endinterface

>>> hw/rtl/vsp_cfg_if.sv
interface vsp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

>>> hw/rtl/vsp_front.sv
module vsp_front
	import vsp_pkg::*;
#(
	parameter int MEM_DEPTH = 65536
) (
	vsp_cmd_if.sink cmd,
	input  logic    busy,
	input  logic    push_ready,
	output logic    push_valid,
	output op_t     push_op
);

	localparam logic [31:0] DEPTH_W = 32'(MEM_DEPTH);

	logic keep;

	assign cmd.ready = push_ready && !busy;

	always_comb begin
		push_op.addr     = cmd.load_address;
		push_op.sample   = cmd.load_sample;
		push_op.play_req = cmd.play_request;
		push_op.seek     = cmd.seek_frame;
		push_op.kind     = K_LOAD;
		keep             = 1'b1;
		unique case (cmd.opcode)
			OP_LOAD: begin
				// drop stores beyond the memory
				push_op.kind = K_LOAD;
				keep = {16'b0, cmd.load_address} < DEPTH_W;
			end
			OP_TICK:     push_op.kind = K_TICK;
			OP_REWIND:   push_op.kind = K_REWIND;
			OP_SET_PLAY: push_op.kind = K_SET_PLAY;
			OP_SEEK:     push_op.kind = K_SEEK;
			default:     keep = 1'b0;
		endcase
	end

	assign push_valid = cmd.valid && cmd.ready && keep;

endmodule

>>> hw/rtl/vsp_queue.sv
module vsp_queue
	import vsp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  op_t  push_op,
	output logic push_ready,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	op_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != FULL;
	assign head_valid = count_q != '0;
	assign head_op    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/vsp_div.sv
module vsp_div
	import vsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COUNT_W-1:0] dividend,
	input  logic [CH_W-1:0]    divisor,
	output logic               busy,
	output logic [COUNT_W-1:0] quotient
);

	localparam int STEP_W = $clog2(COUNT_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W - 1);

	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] num_q;
	logic [CH_W-1:0]    rem_q;
	logic [CH_W-1:0]    den_q;
	logic [COUNT_W-1:0] quot_q;
	logic [CH_W:0]      trial;
	logic [CH_W:0]      diff;
	logic               ge;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[COUNT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			quot_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				quot_q <= {num_q[COUNT_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[COUNT_W-2:0], ge};
			rem_q <= ge ? diff[CH_W-1:0] : trial[CH_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

>>> hw/rtl/vsp_back.sv
module vsp_back
	import vsp_pkg::*;
#(
	parameter int MEM_DEPTH    = 65536,
	parameter int MAX_CHANNELS = 4,
	parameter int FRAC_BITS    = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	input  op_t            op,
	output logic           op_pop,
	input  cfg_t           cfg,
	vsp_result_if.source   result
);

	localparam int NBANK   = 1 << $clog2(2 * MAX_CHANNELS);
	localparam int LB      = $clog2(NBANK);
	localparam int ROWS    = (MEM_DEPTH + NBANK - 1) / NBANK;
	localparam int RW      = $clog2(ROWS);
	localparam int XW_MIN  = FRAME_W + CH_W + 1;
	localparam int XW      = (LB + RW > XW_MIN) ? LB + RW : XW_MIN;
	localparam int POS_W   = FRAME_W + FRAC_BITS;
	localparam int NPW     = POS_W + 2;
	localparam int NL      = (MAX_CHANNELS < OUT_CH) ? MAX_CHANNELS : OUT_CH;
	localparam int PW      = SAMPLE_W + 2 + FRAC_BITS;
	localparam logic [SAMPLE_W+1:0] ONE_SPEED = {{(SAMPLE_W+1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [PW-1:0]       HALF      = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	// play state
	logic [POS_W-1:0] pos_q;
	logic             playing_q;

	// stage 1: position update and read issue
	logic               is_tick;
	logic               is_load;
	logic               s1_room;
	logic               tick_go;
	logic               has_data;
	logic               run0;
	logic               wrap0;
	logic               run1;
	logic               run2;
	logic [FRAME_W-1:0] frame0;
	logic [FRAME_W-1:0] frame1;
	logic [FRAME_W-1:0] nxt_frame;
	logic [FRAC_BITS-1:0] frac1;
	logic [POS_W-1:0]   skip_pos;
	logic [POS_W-1:0]   seek_pos;
	logic [POS_W-1:0]   end_pos;
	logic [POS_W-1:0]   last_pos;
	logic [POS_W-1:0]   pos1;
	logic [POS_W-1:0]   pos2;
	logic [NPW-1:0]     npos;
	logic               speed_one;
	logic               npos_neg;
	logic               npos_over;
	logic [XW-1:0]      base;
	logic [XW-1:0]      load_word;
	logic [LB-1:0]      wr_bank;
	logic [RW-1:0]      wr_row;
	logic [RW-1:0]      rd_row [NBANK];
	logic [LB-1:0]      sel_a [NL];
	logic [LB-1:0]      sel_b [NL];
	logic               ok_a [NL];
	logic               ok_b [NL];

	// stage 2: read data and interpolation
	logic [SAMPLE_W-1:0]  rd_data [NBANK];
	logic                 s2_valid_q;
	logic                 s2_adv;
	logic [LB-1:0]        sel_a_s2 [NL];
	logic [LB-1:0]        sel_b_s2 [NL];
	logic                 ok_a_s2 [NL];
	logic                 ok_b_s2 [NL];
	logic [FRAC_BITS-1:0] frac_s2;
	logic                 one_s2;
	logic                 playing_s2;
	logic [SAMPLE_W-1:0]  lane_val [NL];

	// output register
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] chan_q [NL];
	logic                playing_out_q;
	logic [SAMPLE_W-1:0] chan_out [OUT_CH];

	assign is_tick  = op_valid && (op.kind == K_TICK);
	assign is_load  = op_valid && (op.kind == K_LOAD);
	assign s2_adv   = s2_valid_q && (!out_valid_q || result.ready);
	assign s1_room  = !s2_valid_q || s2_adv;
	assign op_pop   = op_valid && (!is_tick || s1_room);
	assign tick_go  = is_tick && s1_room;
	assign has_data = cfg.cnt != '0;

	assign skip_pos = {1'b0, cfg.skip, {FRAC_BITS{1'b0}}};
	assign seek_pos = {1'b0, op.seek, {FRAC_BITS{1'b0}}};
	assign end_pos  = {cfg.frame_end, {FRAC_BITS{1'b0}}};
	assign last_pos = (cfg.frame_end != '0) ?
		{cfg.frame_end - 1'b1, {FRAC_BITS{1'b0}}} : '0;

	// Pull an out-of-range start back to the skip frame, or stop
	assign run0   = playing_q && has_data;
	assign frame0 = pos_q[POS_W-1:FRAC_BITS];
	assign wrap0  = run0 && (frame0 >= cfg.frame_end);
	assign pos1   = (wrap0 && cfg.loop_en) ? skip_pos : pos_q;
	assign run1   = run0 && !(wrap0 && !cfg.loop_en);
	assign frame1 = pos1[POS_W-1:FRAC_BITS];
	assign frac1  = pos1[FRAC_BITS-1:0];

	// Advance: unit speed snaps to the next whole frame
	assign speed_one = {{2{cfg.speed[SAMPLE_W-1]}}, cfg.speed} == ONE_SPEED;
	assign nxt_frame = frame1 + 1'b1;
	assign npos = speed_one ? {2'b00, nxt_frame, {FRAC_BITS{1'b0}}} :
		{2'b00, pos1} + {{(NPW-SAMPLE_W){cfg.speed[SAMPLE_W-1]}}, cfg.speed};
	assign npos_neg  = npos[NPW-1];
	assign npos_over = npos[NPW-2:FRAC_BITS] >= {1'b0, cfg.frame_end};

	always_comb begin
		pos2 = pos1;
		run2 = run1;
		priority if (!run1) begin
			pos2 = pos1;
		end else if (npos_neg) begin
			pos2 = cfg.loop_en ? last_pos : '0;
			run2 = cfg.loop_en;
		end else if (npos_over) begin
			pos2 = cfg.loop_en ? skip_pos : end_pos;
			run2 = cfg.loop_en;
		end else begin
			pos2 = npos[POS_W-1:0];
		end
	end

	// Word address of the frame; both frames span at most NBANK words
	assign base = {{(XW-FRAME_W){1'b0}}, frame1} * {{(XW-CH_W){1'b0}}, cfg.ch};

	always_comb begin
		logic [LB-1:0] off;
		logic [XW-1:0] word;
		for (int b = 0; b < NBANK; b++) begin
			off       = LB'(b) - base[LB-1:0];
			word      = base + {{(XW-LB){1'b0}}, off};
			rd_row[b] = word[LB +: RW];
		end
	end

	always_comb begin
		for (int c = 0; c < NL; c++) begin
			sel_a[c] = base[LB-1:0] + LB'(c);
			sel_b[c] = base[LB-1:0] + LB'(cfg.ch) + LB'(c);
			ok_a[c]  = run1 && (CH_W'(c) < cfg.ch) &&
				(base + XW'(c) < XW'(cfg.cnt));
			ok_b[c]  = run1 && (CH_W'(c) < cfg.ch) &&
				(base + XW'(cfg.ch) + XW'(c) < XW'(cfg.cnt));
		end
	end

	assign load_word = {{(XW-16){1'b0}}, op.addr};
	assign wr_bank   = load_word[LB-1:0];
	assign wr_row    = load_word[LB +: RW];

	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		logic [SAMPLE_W-1:0] bank_mem [ROWS];
		always_ff @(posedge clk) begin
			if (is_load && (wr_bank == LB'(b))) bank_mem[wr_row] <= op.sample;
			if (tick_go) rd_data[b] <= bank_mem[rd_row[b]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			playing_q <= 1'b0;
		end else if (op_pop) begin
			unique case (op.kind)
				K_LOAD: ;
				K_TICK: begin
					pos_q     <= pos2;
					playing_q <= run2;
				end
				K_REWIND: begin
					pos_q     <= skip_pos;
					playing_q <= has_data;
				end
				K_SET_PLAY: playing_q <= op.play_req && has_data;
				K_SEEK:     pos_q <= seek_pos;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s2_valid_q <= 1'b0;
		else if (s1_room) s2_valid_q <= tick_go;
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			sel_a_s2   <= sel_a;
			sel_b_s2   <= sel_b;
			ok_a_s2    <= ok_a;
			ok_b_s2    <= ok_b;
			frac_s2    <= frac1;
			one_s2     <= speed_one;
			playing_s2 <= run2;
		end
	end

	// a + floor(((b - a) * frac + half) / 2^FRAC_BITS), rounds half up
	always_comb begin
		logic signed [SAMPLE_W-1:0] a;
		logic signed [SAMPLE_W-1:0] b;
		logic signed [SAMPLE_W:0]   d;
		logic signed [PW-1:0]       dx;
		logic signed [PW-1:0]       fx;
		logic signed [PW-1:0]       prod;
		logic signed [PW-1:0]       rnd;
		logic signed [PW-1:0]       q;
		for (int c = 0; c < NL; c++) begin
			a    = ok_a_s2[c] ? rd_data[sel_a_s2[c]] : '0;
			b    = ok_b_s2[c] ? rd_data[sel_b_s2[c]] : '0;
			d    = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
			dx   = PW'(d);
			fx   = {{(PW-FRAC_BITS){1'b0}}, frac_s2};
			prod = dx * fx;
			rnd  = prod + HALF;
			q    = rnd >>> FRAC_BITS;
			lane_val[c] = one_s2 ? a : a + q[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (s2_adv) out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			chan_q        <= lane_val;
			playing_out_q <= playing_s2;
		end
	end

	for (genvar c = 0; c < OUT_CH; c++) begin : g_out
		if (c < NL) begin : g_used
			assign chan_out[c] = chan_q[c];
		end else begin : g_zero
			assign chan_out[c] = '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.chan0_out  = chan_out[0];
	assign result.chan1_out  = chan_out[1];
	assign result.chan2_out  = chan_out[2];
	assign result.chan3_out  = chan_out[3];
	assign result.is_playing = playing_out_q;

endmodule

>>> hw/rtl/variable_speed_sample_player.sv
// Variable-speed player for interleaved 16-bit multichannel samples.
// cmd channel: one transaction per command (load word, frame tick, rewind
// and play, set play, seek). Only a frame tick produces a result transaction
// on the result channel: up to four Q1.15 channel samples and the play state.
// cfg channel: register writes (channel count, loop enable, skip frames,
// speed, sample count), always ready; write only while the block is idle.
// Throughput: one command per cycle sustained while no division runs and the result
// receiver keeps up. The back end serves a tick from one memory access: the
// sample memory is split into banks by low address bits, so both adjacent
// frames come out of one registered read. A tick's result passes the queue
// entry, the read/position update and the output register before it is valid.
// A write to channel count or sample count starts a 17-step division for
// the frame count; cmd.ready stays low until the division is done.
// Reset: position 0, not playing, registers at their reset values; sample
// memory contents are undefined until loaded.
// When the result receiver stalls, the output register holds its result,
// the interpolation stage and then the two-entry queue fill, and cmd.ready
// drops; loads and other commands still drain while no tick is blocked.
module variable_speed_sample_player
	import vsp_pkg::*;
#(
	parameter int MEM_DEPTH    = 65536,
	parameter int MAX_CHANNELS = 4,
	parameter int FRAC_BITS    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	vsp_cmd_if.sink       cmd,
	vsp_result_if.source  result,
	vsp_cfg_if.sink       cfg
);

	localparam logic [31:0]         DEPTH_W     = 32'(MEM_DEPTH);
	localparam logic [CH_W-1:0]     MAX_CH      = CH_W'(MAX_CHANNELS);
	localparam logic [SAMPLE_W-1:0] SPEED_RESET = SAMPLE_W'(1 << FRAC_BITS);

	logic [2:0]          channel_count_q;
	logic                loop_enable_q;
	logic [15:0]         skip_frames_q;
	logic [SAMPLE_W-1:0] speed_q;
	logic [COUNT_W-1:0]  sample_count_q;
	logic                cfg_fire;
	logic                div_start_q;
	logic                div_busy;
	logic                busy;
	logic [CH_W-1:0]     ch_eff;
	logic [COUNT_W-1:0]  cnt_eff;
	logic [COUNT_W-1:0]  frame_end;
	cfg_t                cfg_eff;

	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic head_valid;
	op_t  head_op;
	logic pop;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= 3'd1;
			loop_enable_q   <= 1'b0;
			skip_frames_q   <= '0;
			speed_q         <= SPEED_RESET;
			sample_count_q  <= '0;
		end else if (cfg_fire) begin
			unique case (cfg.index)
				CFG_CHANNEL_COUNT: channel_count_q <= cfg.data[2:0];
				CFG_LOOP_ENABLE:   loop_enable_q   <= cfg.data[0];
				CFG_SKIP_FRAMES:   skip_frames_q   <= cfg.data[15:0];
				CFG_SPEED:         speed_q         <= cfg.data[SAMPLE_W-1:0];
				CFG_SAMPLE_COUNT:  sample_count_q  <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Registered kick for the frame-count division, set by the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_start_q <= 1'b0;
		else div_start_q <= cfg_fire &&
			((cfg.index == CFG_CHANNEL_COUNT) || (cfg.index == CFG_SAMPLE_COUNT));
	end

	// Zero channels act as one; clamp to MAX_CHANNELS
	always_comb begin
		priority if (channel_count_q == 3'd0) ch_eff = CH_W'(1);
		else if ({1'b0, channel_count_q} > MAX_CH) ch_eff = MAX_CH;
		else ch_eff = {1'b0, channel_count_q};
	end

	// Clamp the sample count to the memory
	assign cnt_eff = ({{(32-COUNT_W){1'b0}}, sample_count_q} > DEPTH_W) ?
		DEPTH_W[COUNT_W-1:0] : sample_count_q;

	vsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (cnt_eff),
		.divisor  (ch_eff),
		.busy     (div_busy),
		.quotient (frame_end)
	);

	assign busy = div_start_q || div_busy;

	always_comb begin
		cfg_eff.ch        = ch_eff;
		cfg_eff.cnt       = cnt_eff;
		cfg_eff.frame_end = frame_end;
		cfg_eff.loop_en   = loop_enable_q;
		cfg_eff.skip      = skip_frames_q;
		cfg_eff.speed     = speed_q;
	end

	vsp_front #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_front (
		.cmd        (cmd),
		.busy       (busy),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_op    (push_op)
	);

	vsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	vsp_back #(
		.MEM_DEPTH    (MEM_DEPTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.FRAC_BITS    (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (head_valid),
		.op       (head_op),
		.op_pop   (pop),
		.cfg      (cfg_eff),
		.result   (result)
	);

endmodule
